// ===== rtl/imu_afp_pkg.sv =====
// Shared types and constants for the attitude frame parser.
`timescale 1ns / 1ps
`default_nettype none

package imu_afp_pkg;

  typedef enum logic [2:0] {
    PH_HEAD1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_SUM   = 3'd5
  } parse_phase_t;

  localparam int unsigned ANGLE_BYTES = 6;

  typedef logic [ANGLE_BYTES-1:0][7:0] angle_bytes_t;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] ATT_ID_RESET = 8'h01;

  localparam logic signed [11:0] ANGLE_SCALE = 12'sd1800;
  localparam int unsigned SCALE_SHIFT = 15;
  localparam logic signed [27:0] SCALE_BIAS = 28'sd32767;

endpackage

`default_nettype wire

// ===== rtl/imu_afp_scale.sv =====
// Converts one raw little-endian int16 angle into tenths of a degree.
`timescale 1ns / 1ps
`default_nettype none

module imu_afp_scale (
  input  wire logic [15:0] raw_word,
  output logic signed [11:0] tenths
);
  import imu_afp_pkg::*;

  logic signed [27:0] prod;
  logic signed [27:0] biased;

  // Negative products get a bias so that the shift truncates toward zero.
  always_comb begin
    prod   = 28'($signed(raw_word)) * 28'(ANGLE_SCALE);
    biased = prod + (prod[27] ? SCALE_BIAS : 28'sd0);
    tenths = biased[SCALE_SHIFT+11:SCALE_SHIFT];
  end

endmodule

`default_nettype wire

// ===== rtl/imu_afp_parser.sv =====
// Frame parser state machine with checksum and angle byte capture.
`timescale 1ns / 1ps
`default_nettype none

module imu_afp_parser #(
  parameter int unsigned MAX_PAYLOAD = 28
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] att_id,
  output logic hit,
  output imu_afp_pkg::angle_bytes_t angle_bytes
);
  import imu_afp_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

  parse_phase_t phase_r, phase_nxt;
  logic [7:0] id_r, id_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  angle_bytes_t ang_r;

  logic is_sync;
  logic len_bad;
  logic sum_good;
  logic [LEN_W-1:0] cnt_inc;

  always_comb begin
    is_sync  = (rx_byte == SYNC_BYTE);
    len_bad  = ({1'b0, rx_byte} > 9'(MAX_PAYLOAD));
    sum_good = (rx_byte == sum_r) && (id_r == att_id) &&
               (len_r >= LEN_W'(ANGLE_BYTES));
    cnt_inc  = cnt_r + 1'b1;
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      case (phase_r)
        PH_HEAD1: phase_nxt = is_sync ? PH_HEAD2 : PH_HEAD1;
        PH_HEAD2: phase_nxt = is_sync ? PH_ID : PH_HEAD1;
        PH_ID:    phase_nxt = PH_LEN;
        PH_LEN: begin
          if (len_bad) begin
            phase_nxt = is_sync ? PH_HEAD2 : PH_HEAD1;
          end else if (rx_byte == 8'd0) begin
            phase_nxt = PH_SUM;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA:  phase_nxt = (cnt_inc >= len_r) ? PH_SUM : PH_DATA;
        PH_SUM: begin
          if (sum_good) begin
            phase_nxt = PH_HEAD1;
          end else begin
            phase_nxt = is_sync ? PH_HEAD2 : PH_HEAD1;
          end
        end
        default:  phase_nxt = PH_HEAD1;
      endcase
    end
  end

  // Frame fields and running checksum.
  always_comb begin
    id_nxt  = id_r;
    len_nxt = len_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    hit     = 1'b0;
    if (step) begin
      case (phase_r)
        PH_HEAD1: begin
          if (is_sync) begin
            sum_nxt = rx_byte;
          end
        end
        PH_HEAD2: begin
          if (is_sync) begin
            sum_nxt = sum_r + rx_byte;
          end
        end
        PH_ID: begin
          id_nxt  = rx_byte;
          sum_nxt = sum_r + rx_byte;
        end
        PH_LEN: begin
          if (len_bad) begin
            if (is_sync) begin
              sum_nxt = rx_byte;
            end
          end else begin
            len_nxt = LEN_W'(rx_byte);
            cnt_nxt = '0;
            sum_nxt = sum_r + rx_byte;
          end
        end
        PH_DATA: begin
          cnt_nxt = cnt_inc;
          sum_nxt = sum_r + rx_byte;
        end
        PH_SUM: begin
          if (sum_good) begin
            hit = 1'b1;
          end else if (is_sync) begin
            sum_nxt = rx_byte;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD1;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Only the first six payload bytes of a frame are kept.
  always_ff @(posedge clk) begin
    if (step && (phase_r == PH_DATA) && (cnt_r < LEN_W'(ANGLE_BYTES))) begin
      ang_r[cnt_r[2:0]] <= rx_byte;
    end
  end

  assign angle_bytes = ang_r;

endmodule

`default_nettype wire

// ===== rtl/imu_attitude_frame_parser.sv =====
// Top level of the attitude frame parser: input register, parser and result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received serial byte per item and finds frames of the form 0x55 0x55, id,
// length, payload, additive checksum. A frame whose id matches the configured attitude id,
// whose checksum is good and whose payload holds at least six bytes yields one item of roll,
// pitch and yaw in tenths of a degree. The block accepts one byte per cycle while in_stall
// is low. Each accepted byte waits in the input register and is parsed from there; when
// the checksum byte of a good frame is parsed, the result register takes the angles and
// offers them. While a result waits on out_stall, the next byte is held in the input
// register and in_stall rises only when that register is also full.

module imu_attitude_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = 28
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [11:0] out_roll_tenths,
  output logic signed [11:0] out_pitch_tenths,
  output logic signed [11:0] out_yaw_tenths
);
  import imu_afp_pkg::*;

  logic [7:0] cfg_id_r;
  logic byte_vld_r, byte_vld_nxt;
  logic [7:0] byte_r;
  logic out_vld_r, out_vld_nxt;
  logic signed [11:0] roll_r, pitch_r, yaw_r;

  logic step;
  logic hit;
  angle_bytes_t angle_bytes;
  logic signed [11:0] roll_c, pitch_c, yaw_c;

  always_comb begin
    step     = byte_vld_r && (!out_vld_r || !out_stall);
    in_stall = byte_vld_r && !step;
    byte_vld_nxt = in_stall ? byte_vld_r : in_valid;
    if (hit) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_id_r   <= ATT_ID_RESET;
      byte_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_id_r <= cfg_wr_data;
      end
      byte_vld_r <= byte_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r <= in_rx_byte;
    end
    if (hit) begin
      roll_r  <= roll_c;
      pitch_r <= pitch_c;
      yaw_r   <= yaw_c;
    end
  end

  imu_afp_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk(clk),
    .rst_n(rst_n),
    .step(step),
    .rx_byte(byte_r),
    .att_id(cfg_id_r),
    .hit(hit),
    .angle_bytes(angle_bytes)
  );

  imu_afp_scale u_roll (
    .raw_word({angle_bytes[1], angle_bytes[0]}),
    .tenths(roll_c)
  );

  imu_afp_scale u_pitch (
    .raw_word({angle_bytes[3], angle_bytes[2]}),
    .tenths(pitch_c)
  );

  imu_afp_scale u_yaw (
    .raw_word({angle_bytes[5], angle_bytes[4]}),
    .tenths(yaw_c)
  );

  assign out_valid        = out_vld_r;
  assign out_roll_tenths  = roll_r;
  assign out_pitch_tenths = pitch_r;
  assign out_yaw_tenths   = yaw_r;

endmodule

`default_nettype wire
